FILE: rtl/core/murmur64a_hash_engine_unit_assert.svh
// Assertion macros shared by the hash engine RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef MURMUR64A_HASH_ENGINE_UNIT_ASSERT_SVH
`define MURMUR64A_HASH_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MM64A_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MM64A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mm64a_pkg.sv
package mm64a_pkg;

  localparam int unsigned KEY_LEN_W       = 32;
  localparam int unsigned WORD_W          = 64;
  localparam int unsigned LENGTH_BITS_DEF = 32;

  localparam logic [63:0] MUR_M = 64'hc6a4a7935bd1e995;
  localparam int unsigned MUR_R = 47;
  // Byte index within a word.
  localparam logic [2:0]  BYTE_IDX_MASK = 3'h7;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_MUL
  } seq_state_e;

  // What the running multiply belongs to.
  typedef enum logic [2:0] {
    PH_INIT,
    PH_K1,
    PH_K2,
    PH_H,
    PH_FIN
  } mul_phase_e;

  typedef struct packed {
    logic [KEY_LEN_W-1:0] key_length;
    logic [WORD_W-1:0]    key_word;
  } key_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] hash_value;
  } hash_rsp_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] product;
  } mul_rsp_t;

  // Keeps the lowest n bytes of a word.
  function automatic logic [WORD_W-1:0] tail_mask(input logic [2:0] n);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[i*8 +: 8] = (3'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // h ^ (h >> r), the shift-xor step used in the word mix and finalizer.
  function automatic logic [WORD_W-1:0] shift_xor(input logic [WORD_W-1:0] h);
    return h ^ (h >> MUR_R);
  endfunction

endpackage

FILE: rtl/core/mm64a_stream_if.sv
interface mm64a_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/mm64a_mul.sv
// Multiplies a 64-bit operand by the hash constant modulo 2^64, using one
// 32x32 multiplier, step by step. The product is valid while done is high.
module mm64a_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mm64a_pkg::mul_req_t req_i,
  output mm64a_pkg::mul_rsp_t rsp_o
);
  import mm64a_pkg::*;

  logic [WORD_W-1:0] a_q, a_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [1:0]        step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [31:0]       op_a, op_b;
  logic [63:0]       prod;

  // Step 0: aL*mL, step 1: aL*mH, step 2: aH*mL. The upper cross terms
  // fall outside the 64-bit result.
  always_comb begin
    op_a = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
    op_b = (step_q == 2'd1) ? MUR_M[63:32] : MUR_M[31:0];
    prod = 64'(op_a) * 64'(op_b);
  end

  always_comb begin
    a_d    = a_q;
    acc_d  = acc_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d    = req_i.operand;
      step_d = 2'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (step_q == 2'd0) begin
        acc_d = prod;
      end else begin
        acc_d[63:32] = acc_q[63:32] + prod[31:0];
      end
      step_d = step_q + 2'd1;
      if (step_q == 2'd2) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

FILE: rtl/core/murmur64a_hash_engine_unit.sv
// Sequence: each 64-bit multiply runs on the shared 32x32 multiplier. A message
// starts with the seed/length multiply; a full word takes K1, K2 and H, a tail
// word H only, the last item adds the finalizer; empty key: start and finalizer.
// Throughput: one request at a time; ready stays low while the multiply
// sequence runs, and a finished hash waits while the previous one is untaken.
// Reset: async active low; clears sequencer, message tracking and the seed.
`include "murmur64a_hash_engine_unit_assert.svh"

module murmur64a_hash_engine_unit #(
  parameter int unsigned LENGTH_BITS = mm64a_pkg::LENGTH_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mm64a_pkg::WORD_W-1:0] cfg_wdata_i,
  mm64a_stream_if.sink              key_req_i,
  mm64a_stream_if.source            hash_rsp_o
);
  import mm64a_pkg::*;

  // Only the low bits of the 32-bit length field count, so the byte
  // counter is never wider than the length field itself.
  localparam int unsigned LEN_W = (LENGTH_BITS > KEY_LEN_W) ? KEY_LEN_W : LENGTH_BITS;

  seq_state_e        state_q, state_d;
  mul_phase_e        phase_q, phase_d;
  logic [WORD_W-1:0] h_q, h_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic              in_msg_q, in_msg_d;
  logic [WORD_W-1:0] seed_q;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] hash_q, hash_d;
  // Set while the finalizer product sits in the multiplier because the
  // previous hash has not been taken yet.
  logic              fin_hold_q, fin_hold_d;

  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;

  logic              accept;
  logic [LEN_W-1:0]  len;
  // Hash and word that a key word is mixed from: the live request while
  // idle, or the stored word right after the seed/length multiply.
  logic [WORD_W-1:0] disp_h, disp_word;
  logic              rem_full;
  logic [WORD_W-1:0] init_h;

  mm64a_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // The output register parts the two sides: a waiting hash only holds up
  // the sequencer when the next message is about to finish.
  assign key_req_i.ready    = (state_q == ST_IDLE);
  assign accept             = key_req_i.valid && key_req_i.ready;
  assign len                = key_req_i.payload.key_length[LEN_W-1:0];
  assign rem_full           = |rem_q[LEN_W-1:3];
  assign init_h             = seed_q ^ mul_rsp.product;

  assign hash_rsp_o.valid              = out_valid_q;
  assign hash_rsp_o.payload.hash_value = hash_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    h_d         = h_q;
    word_d      = word_q;
    rem_d       = rem_q;
    in_msg_d    = in_msg_q;
    out_valid_d = out_valid_q;
    hash_d      = hash_q;
    fin_hold_d  = fin_hold_q;
    mul_req     = '0;

    if (state_q == ST_IDLE) begin
      disp_h    = h_q;
      disp_word = key_req_i.payload.key_word;
    end else begin
      disp_h    = init_h;
      disp_word = word_q;
    end

    if (out_valid_q && hash_rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          word_d  = key_req_i.payload.key_word;
          state_d = ST_MUL;
          mul_req.start = 1'b1;
          if (!in_msg_q) begin
            // New message: start from seed ^ (length * m).
            rem_d           = len;
            phase_d         = PH_INIT;
            mul_req.operand = 64'(len);
          end else if (rem_full) begin
            phase_d         = PH_K1;
            mul_req.operand = disp_word;
            rem_d           = rem_q - LEN_W'(8);
          end else begin
            phase_d         = PH_H;
            mul_req.operand = disp_h ^ (disp_word & tail_mask(rem_q[2:0] & BYTE_IDX_MASK));
            rem_d           = '0;
          end
        end
      end
      ST_MUL: begin
        if (mul_rsp.done || fin_hold_q) begin
          mul_req.start = 1'b1;
          unique case (phase_q)
            PH_INIT: begin
              h_d = init_h;
              if (rem_q == '0) begin
                // Empty key: finalize straight from the start value.
                phase_d         = PH_FIN;
                mul_req.operand = shift_xor(init_h);
              end else begin
                in_msg_d = 1'b1;
                if (rem_full) begin
                  phase_d         = PH_K1;
                  mul_req.operand = disp_word;
                  rem_d           = rem_q - LEN_W'(8);
                end else begin
                  phase_d         = PH_H;
                  mul_req.operand =
                    disp_h ^ (disp_word & tail_mask(rem_q[2:0] & BYTE_IDX_MASK));
                  rem_d           = '0;
                end
              end
            end
            PH_K1: begin
              phase_d         = PH_K2;
              mul_req.operand = shift_xor(mul_rsp.product);
            end
            PH_K2: begin
              phase_d         = PH_H;
              mul_req.operand = h_q ^ mul_rsp.product;
            end
            PH_H: begin
              h_d = mul_rsp.product;
              if (rem_q == '0) begin
                phase_d         = PH_FIN;
                mul_req.operand = shift_xor(mul_rsp.product);
              end else begin
                // More words to come; wait for the next request.
                mul_req.start = 1'b0;
                state_d       = ST_IDLE;
              end
            end
            PH_FIN: begin
              mul_req.start = 1'b0;
              if (out_valid_q && !hash_rsp_o.ready) begin
                // The previous hash is still waiting; the multiplier keeps
                // the product until the output register frees up.
                fin_hold_d = 1'b1;
              end else begin
                fin_hold_d  = 1'b0;
                hash_d      = shift_xor(mul_rsp.product);
                out_valid_d = 1'b1;
                in_msg_d    = 1'b0;
                state_d     = ST_IDLE;
              end
            end
            default: begin
              mul_req.start = 1'b0;
              state_d       = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_INIT;
      h_q         <= '0;
      rem_q       <= '0;
      in_msg_q    <= 1'b0;
      seed_q      <= '0;
      out_valid_q <= 1'b0;
      fin_hold_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      h_q         <= h_d;
      rem_q       <= rem_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
      fin_hold_q  <= fin_hold_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    hash_q <= hash_d;
  end

  // Every accepted request starts a multiply.
  `MM64A_ASSERT_NEXT(a_accept_starts_mul, accept, state_q == ST_MUL, "request not started")
  // A finished hash always closes the message.
  `MM64A_ASSERT_NOW(a_result_closes_msg, $rose(out_valid_q), !in_msg_q, "hash inside message")
  // While waiting inside a message, bytes must remain.
  `MM64A_ASSERT_NOW(a_rem_nonzero, (state_q == ST_IDLE) && in_msg_q, rem_q != '0, "no bytes left")
  // The multiplier only reports completion while the sequencer waits on it.
  `MM64A_ASSERT_NOW(a_done_in_mul, mul_rsp.done, state_q == ST_MUL, "stray multiply done")

endmodule
